// ----- hdl/rrp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_pkg: shared definitions for the request parser
// Character codes, result kinds, widths and the result record passed from the
// parse core to the output register.
// ----------------------------------------------------------------------------
package rrp_pkg;

	// Default widths for the top level parameters
	localparam int ARG_INDEX_BITS_DEF = 16;
	localparam int LENGTH_BITS_DEF    = 32;

	// Fixed port widths
	localparam int BYTE_W      = 8;
	localparam int ARG_INDEX_W = 16;

	// Number accumulator holds magnitudes up to 2^31-1
	localparam int NUM_BITS = 31;

	// Protocol characters
	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_ARG_END = 2'd1,
		KIND_EMPTY   = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	// One result from the parse core
	typedef struct packed {
		logic                    valid;
		kind_t                   kind;
		logic [BYTE_W-1:0]       data_byte;
		logic [ARG_INDEX_W-1:0]  arg_index;
		logic                    last_arg;
	} res_t;

endpackage

// ----- hdl/resp_request_parser_top.sv -----
`timescale 1ns / 1ps
// A request byte lands in the input register, is parsed by the core and its
// result (if any) is registered in the output register and shown at out_valid.
// Throughput: one byte per cycle while out_ready stays high; while a result
// waits, one more byte can still be taken into the input register.
// Reset: arst_n clears the parser to idle, expecting '*', and empties both
// registers.
// ----------------------------------------------------------------------------
// resp_request_parser_top: byte-serial request parser
// Input register, parse core, and output register with valid/ready on both
// sides.
// ----------------------------------------------------------------------------
module resp_request_parser_top
	import rrp_pkg::*;
#(
	parameter int ARG_INDEX_BITS = ARG_INDEX_BITS_DEF,
	parameter int LENGTH_BITS    = LENGTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [BYTE_W-1:0]      in_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             kind,
	output logic [BYTE_W-1:0]      data_byte,
	output logic [ARG_INDEX_W-1:0] arg_index,
	output logic                   last_arg
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              step;
	res_t              res;
	res_t              res_s2;

	// Byte advances once the output slot is free or being drained
	assign step     = valid_s1 && (!res_s2.valid || out_ready);
	assign in_ready = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	rrp_core #(
		.ARG_INDEX_BITS(ARG_INDEX_BITS),
		.LENGTH_BITS   (LENGTH_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.in_byte(byte_s1),
		.res    (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (step) begin
			res_s2 <= res;
		end else if (out_ready) begin
			res_s2.valid <= 1'b0;
		end
	end

	assign out_valid = res_s2.valid;
	assign kind      = res_s2.kind;
	assign data_byte = res_s2.data_byte;
	assign arg_index = res_s2.arg_index;
	assign last_arg  = res_s2.last_arg;

endmodule

// ----- hdl/rrp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_core: request parse state machine
// Holds the parse phase, number accumulator and argument/byte counters.
// Decodes one registered byte per step and presents at most one result.
// ----------------------------------------------------------------------------
module rrp_core
	import rrp_pkg::*;
#(
	parameter int ARG_INDEX_BITS = ARG_INDEX_BITS_DEF,
	parameter int LENGTH_BITS    = LENGTH_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] in_byte,
	output res_t              res
);

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_CNT_NUM   = 4'd1,
		PH_CNT_LF    = 4'd2,
		PH_LEN_START = 4'd3,
		PH_LEN_NUM   = 4'd4,
		PH_LEN_LF    = 4'd5,
		PH_PAYLOAD   = 4'd6,
		PH_PAY_CR    = 4'd7,
		PH_PAY_LF    = 4'd8
	} phase_t;

	phase_t                    phase_q, phase_d;
	logic [NUM_BITS-1:0]       acc_q, acc_d;
	logic                      neg_q, neg_d;
	logic                      saw_q, saw_d;
	logic [ARG_INDEX_BITS-1:0] expected_q, expected_d;
	logic [ARG_INDEX_BITS-1:0] done_q, done_d;
	logic [LENGTH_BITS-1:0]    left_q, left_d;

	// Number decode: acc*10 + digit with overflow check
	logic                  is_digit;
	logic [NUM_BITS+3:0]   acc10;
	logic                  num_ovf;
	logic                  cnt_ovf;
	logic                  len_ovf;
	logic [NUM_BITS-1:0]   acc_cnt_hi;
	logic [NUM_BITS-1:0]   acc_len_hi;
	logic [ARG_INDEX_BITS:0] done_inc;
	logic                  is_last;
	logic [LENGTH_BITS-1:0] left_dec;

	assign is_digit   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign acc10      = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
	                    + {{(NUM_BITS){1'b0}}, in_byte[3:0]};
	assign num_ovf    = |acc10[NUM_BITS+3:NUM_BITS];
	assign acc_cnt_hi = acc_q >> ARG_INDEX_BITS;
	assign acc_len_hi = acc_q >> LENGTH_BITS;
	assign cnt_ovf    = |acc_cnt_hi;
	assign len_ovf    = |acc_len_hi;
	assign done_inc   = {1'b0, done_q} + {{ARG_INDEX_BITS{1'b0}}, 1'b1};
	assign is_last    = done_inc >= {1'b0, expected_q};
	assign left_dec   = left_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

	// Next state and result
	always_comb begin
		logic fail;
		fail       = 1'b0;
		phase_d    = phase_q;
		acc_d      = acc_q;
		neg_d      = neg_q;
		saw_d      = saw_q;
		expected_d = expected_q;
		done_d     = done_q;
		left_d     = left_q;
		res        = '0;
		res.kind   = KIND_PAYLOAD;

		unique case (phase_q)
			PH_CNT_NUM, PH_LEN_NUM: begin
				if (in_byte == CH_MINUS && !neg_q && !saw_q) begin
					neg_d = 1'b1;
				end else if (is_digit) begin
					if (num_ovf) begin
						fail = 1'b1;
					end else begin
						acc_d = acc10[NUM_BITS-1:0];
						saw_d = 1'b1;
					end
				end else if (in_byte == CH_CR && saw_q) begin
					phase_d = (phase_q == PH_CNT_NUM) ? PH_CNT_LF : PH_LEN_LF;
				end else begin
					fail = 1'b1;
				end
			end
			PH_CNT_LF: begin
				if (in_byte != CH_LF) begin
					fail = 1'b1;
				end else if (neg_q || acc_q == '0) begin
					// count of zero or minus one: empty request
					if (acc_q > NUM_BITS'(1)) begin
						fail = 1'b1;
					end else begin
						phase_d    = PH_IDLE;
						acc_d      = '0;
						neg_d      = 1'b0;
						saw_d      = 1'b0;
						expected_d = '0;
						done_d     = '0;
						left_d     = '0;
						res.valid  = 1'b1;
						res.kind   = KIND_EMPTY;
					end
				end else if (cnt_ovf) begin
					fail = 1'b1;
				end else begin
					expected_d = acc_q[ARG_INDEX_BITS-1:0];
					done_d     = '0;
					phase_d    = PH_LEN_START;
				end
			end
			PH_LEN_START: begin
				if (in_byte != CH_DOLLAR) begin
					fail = 1'b1;
				end else begin
					acc_d   = '0;
					neg_d   = 1'b0;
					saw_d   = 1'b0;
					phase_d = PH_LEN_NUM;
				end
			end
			PH_LEN_LF: begin
				if (in_byte != CH_LF || (neg_q && acc_q != '0) || len_ovf) begin
					fail = 1'b1;
				end else begin
					left_d  = LENGTH_BITS'(acc_q);
					phase_d = (acc_q == '0) ? PH_PAY_CR : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = PH_PAY_CR;
				end
				res.valid     = 1'b1;
				res.kind      = KIND_PAYLOAD;
				res.data_byte = in_byte;
				res.arg_index = ARG_INDEX_W'(done_q);
			end
			PH_PAY_CR: begin
				if (in_byte != CH_CR) begin
					fail = 1'b1;
				end else begin
					phase_d = PH_PAY_LF;
				end
			end
			PH_PAY_LF: begin
				if (in_byte != CH_LF) begin
					fail = 1'b1;
				end else begin
					if (is_last) begin
						phase_d    = PH_IDLE;
						acc_d      = '0;
						neg_d      = 1'b0;
						saw_d      = 1'b0;
						expected_d = '0;
						done_d     = '0;
						left_d     = '0;
					end else begin
						done_d  = done_inc[ARG_INDEX_BITS-1:0];
						phase_d = PH_LEN_START;
					end
					res.valid     = 1'b1;
					res.kind      = KIND_ARG_END;
					res.arg_index = ARG_INDEX_W'(done_q);
					res.last_arg  = is_last;
				end
			end
			default: begin
				// idle, and any unused phase code
				if (in_byte != CH_STAR) begin
					fail   = 1'b1;
					done_d = '0;
				end else begin
					phase_d    = PH_CNT_NUM;
					acc_d      = '0;
					neg_d      = 1'b0;
					saw_d      = 1'b0;
					expected_d = '0;
					done_d     = '0;
					left_d     = '0;
				end
			end
		endcase

		// Protocol error: report completed argument count, return to idle
		if (fail) begin
			res           = '0;
			res.valid     = 1'b1;
			res.kind      = KIND_ERROR;
			res.arg_index = (phase_q == PH_IDLE) ? '0 : ARG_INDEX_W'(done_q);
			phase_d       = PH_IDLE;
			acc_d         = '0;
			neg_d         = 1'b0;
			saw_d         = 1'b0;
			expected_d    = '0;
			done_d        = '0;
			left_d        = '0;
		end
	end

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			acc_q      <= '0;
			neg_q      <= 1'b0;
			saw_q      <= 1'b0;
			expected_q <= '0;
			done_q     <= '0;
			left_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			acc_q      <= acc_d;
			neg_q      <= neg_d;
			saw_q      <= saw_d;
			expected_q <= expected_d;
			done_q     <= done_d;
			left_q     <= left_d;
		end
	end

endmodule

// ----- sim/tb_resp_request_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resp_request_parser_top: self-checking bench for the byte-serial parser
// Drives request bytes through the valid/ready input and mirrors every
// accepted byte in a local parser model. The model holds the results that
// should appear at the output. Directed sequences cover well-formed and empty
// requests and framing, number and length errors. A long output hold-off fills the block. A random
// stream of mostly well-formed requests follows, with broken ones and noise.
// ----------------------------------------------------------------------------
module tb_resp_request_parser_top;
	import rrp_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 400;
	localparam int TOTAL_BYTES  = 850;
	localparam logic [63:0] MAG_MAX   = 64'h7FFF_FFFF;
	localparam logic [63:0] COUNT_MAX = (64'd1 << ARG_INDEX_BITS_DEF) - 64'd1;
	localparam logic [63:0] LEN_LIMIT = (64'd1 << LENGTH_BITS_DEF) - 64'd1;
	localparam logic [63:0] LEN_MAX   = (LEN_LIMIT > MAG_MAX) ? MAG_MAX : LEN_LIMIT;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COUNT_DIGITS,
		ST_COUNT_LF,
		ST_ARG_DOLLAR,
		ST_LEN_DIGITS,
		ST_LEN_LF,
		ST_DATA,
		ST_DATA_CR,
		ST_DATA_LF
	} parse_state_t;

	typedef struct packed {
		kind_t                  kind;
		logic [BYTE_W-1:0]      data;
		logic [ARG_INDEX_W-1:0] idx;
		logic                   last;
	} parse_result_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	logic [BYTE_W-1:0]      in_byte   = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [1:0]             kind;
	logic [BYTE_W-1:0]      data_byte;
	logic [ARG_INDEX_W-1:0] arg_index;
	logic                   last_arg;

	parse_result_t     expected_results[$];
	logic [BYTE_W-1:0] stream_q[$];
	int                error_count = 0;
	int                bytes_sent  = 0;
	int                burst_left  = 0;
	int                cycle_count = 0;
	bit                gaps_on     = 1'b1;
	logic              hold_toggle = 1'b0;

	// Parser model state
	parse_state_t pstate    = ST_IDLE;
	logic [31:0]  num_acc   = '0;
	bit           num_neg   = 1'b0;
	bit           num_seen  = 1'b0;
	logic [31:0]  arg_total = '0;
	logic [31:0]  arg_count = '0;
	logic [31:0]  data_left = '0;

	resp_request_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.data_byte (data_byte),
		.arg_index (arg_index),
		.last_arg  (last_arg)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------
	function automatic void clear_number();
		num_acc  = '0;
		num_neg  = 1'b0;
		num_seen = 1'b0;
	endfunction

	function automatic void clear_parser();
		pstate    = ST_IDLE;
		arg_total = '0;
		arg_count = '0;
		data_left = '0;
		clear_number();
	endfunction

	// Protocol violation: report completed args, then back to idle
	function automatic bit parse_error(output parse_result_t r);
		logic [31:0] idx;
		idx = arg_count;
		clear_parser();
		r      = '0;
		r.kind = KIND_ERROR;
		r.idx  = idx[ARG_INDEX_W-1:0];
		return 1'b1;
	endfunction

	function automatic bit predict_byte(input logic [BYTE_W-1:0] b, output parse_result_t r);
		logic [63:0] v;
		logic [31:0] idx;
		bit          is_last;
		r = '0;
		case (pstate)
			ST_COUNT_DIGITS, ST_LEN_DIGITS: begin
				if (b == CH_MINUS && !num_neg && !num_seen) begin
					num_neg = 1'b1;
					return 1'b0;
				end
				if (b >= CH_ZERO && b <= CH_NINE) begin
					v = 64'(num_acc) * 64'd10 + 64'(b - CH_ZERO);
					// overflow is flagged on the digit itself
					if (v > MAG_MAX)
						return parse_error(r);
					num_acc  = v[31:0];
					num_seen = 1'b1;
					return 1'b0;
				end
				if (b == CH_CR && num_seen) begin
					pstate = (pstate == ST_COUNT_DIGITS) ? ST_COUNT_LF : ST_LEN_LF;
					return 1'b0;
				end
				return parse_error(r);
			end
			ST_COUNT_LF: begin
				if (b != CH_LF)
					return parse_error(r);
				// zero, minus zero and minus one mean an empty request
				if (num_neg || num_acc == 0) begin
					if (num_acc > 1)
						return parse_error(r);
					clear_parser();
					r.kind = KIND_EMPTY;
					return 1'b1;
				end
				if (64'(num_acc) > COUNT_MAX)
					return parse_error(r);
				arg_total = num_acc;
				arg_count = '0;
				pstate    = ST_ARG_DOLLAR;
				return 1'b0;
			end
			ST_ARG_DOLLAR: begin
				if (b != CH_DOLLAR)
					return parse_error(r);
				clear_number();
				pstate = ST_LEN_DIGITS;
				return 1'b0;
			end
			ST_LEN_LF: begin
				if (b != CH_LF || (num_neg && num_acc != 0))
					return parse_error(r);
				if (64'(num_acc) > LEN_MAX)
					return parse_error(r);
				data_left = num_acc;
				pstate    = (num_acc == 0) ? ST_DATA_CR : ST_DATA;
				return 1'b0;
			end
			ST_DATA: begin
				data_left = data_left - 1;
				if (data_left == 0)
					pstate = ST_DATA_CR;
				r.kind = KIND_PAYLOAD;
				r.data = b;
				r.idx  = arg_count[ARG_INDEX_W-1:0];
				return 1'b1;
			end
			ST_DATA_CR: begin
				if (b != CH_CR)
					return parse_error(r);
				pstate = ST_DATA_LF;
				return 1'b0;
			end
			ST_DATA_LF: begin
				if (b != CH_LF)
					return parse_error(r);
				idx     = arg_count;
				is_last = (idx + 1 >= arg_total);
				if (is_last) begin
					clear_parser();
				end else begin
					arg_count = idx + 1;
					pstate    = ST_ARG_DOLLAR;
				end
				r.kind = KIND_ARG_END;
				r.idx  = idx[ARG_INDEX_W-1:0];
				r.last = is_last;
				return 1'b1;
			end
			default: begin
				if (b != CH_STAR) begin
					arg_count = '0;
					return parse_error(r);
				end
				clear_parser();
				pstate = ST_COUNT_DIGITS;
				return 1'b0;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Sender: bursts of random length with random gaps in between
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int            gap;
		parse_result_t res;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap = ($urandom_range(3) == 0 || !gaps_on) ? 0 : $urandom_range(8, 1);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		bytes_sent++;
		if (predict_byte(b, res))
			expected_results.push_back(res);
	endtask

	task automatic send_str(input string s);
		foreach (s[i]) send_byte(s[i]);
	endtask

	task automatic send_line(input string s);
		send_str(s);
		send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	task automatic send_stream();
		while (stream_q.size() != 0) send_byte(stream_q.pop_front());
	endtask

	// Builders for the random stream
	task automatic queue_line(input string s);
		foreach (s[i]) stream_q.push_back(s[i]);
		stream_q.push_back(CH_CR);
		stream_q.push_back(CH_LF);
	endtask

	task automatic queue_number(input string lead, input int v);
		string s;
		s = $sformatf("%0d", v);
		if (v == 0 && $urandom_range(3) == 0)
			s = "-0";
		else if (v >= 0 && $urandom_range(7) == 0)
			s = {"0", s};
		queue_line({lead, s});
	endtask

	task automatic queue_request();
		int nargs;
		int len;
		int sel;
		sel = $urandom_range(19);
		if (sel == 0)
			nargs = -$urandom_range(1);
		else if (sel == 1)
			nargs = $urandom_range(40, 5);
		else
			nargs = $urandom_range(4, 1);
		queue_number("*", nargs);
		for (int a = 0; a < nargs; a++) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
			queue_number("$", len);
			repeat (len) stream_q.push_back(BYTE_W'($urandom_range(255)));
			queue_line("");
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: stall pattern that changes mode every window, plus hold-off
	// ------------------------------------------------------------------
	initial begin
		int   stall_cnt;
		int   hold_left;
		logic hold_seen;
		stall_cnt = 0;
		hold_left = 0;
		hold_seen = 1'b0;
		forever begin
			@(posedge clk);
			stall_cnt++;
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case ((stall_cnt / 97) % 4)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(1) == 0);
					2: out_ready <= ($urandom_range(3) == 0);
					default: out_ready <= ((stall_cnt % 8) < 5);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		parse_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, %s %0d data %0h idx %0d last %0b",
					$time, "actual kind", kind, data_byte, arg_index, last_arg);
				error_count++;
			end else begin
				e = expected_results.pop_front();
				check_field("kind", 16'(e.kind), 16'(kind));
				check_field("data_byte", 16'(e.data), 16'(data_byte));
				check_field("arg_index", 16'(e.idx), 16'(arg_index));
				check_field("last_arg", 16'(e.last), 16'(last_arg));
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_bad_leading_byte();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_DOLLAR);
		send_line("*1");
		send_byte("X");
	endtask

	task automatic test_well_formed();
		send_line("*2");
		send_line("$3");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_line("");
		send_line("$0");
		send_line("");
		send_line("*1");
		send_line("$0002");
		send_byte(8'h80);
		send_byte(CH_CR);
		send_line("");
	endtask

	task automatic test_empty_request();
		send_line("*0");
		send_line("*-1");
		send_line("*-0");
		send_line("*-2");
		send_line("*00");
	endtask

	task automatic test_bad_number();
		send_str("*1-");
		send_str("*");
		send_byte(CH_CR);
		send_str("*-");
		send_byte(CH_CR);
		send_str("*3");
		send_byte(CH_CR);
		send_byte("x");
		send_str("*a");
		send_str("*1");
		send_byte(CH_CR);
		send_byte(CH_CR);
		send_str("*--");
	endtask

	task automatic test_overflow();
		send_line("*2147483647");
		send_str("*2147483648");
		send_line("*65536");
		send_line("*65535");
		send_line("$1");
		send_byte("Z");
		send_line("");
		send_byte("!");
		send_line("*1");
		send_str("$2147483648");
		send_line("*1");
		send_str("$99999999999");
	endtask

	task automatic test_length_sign();
		send_line("*1");
		send_line("$-1");
		send_line("*2");
		send_line("$-0");
		send_line("");
		send_line("$-3");
		send_line("*1");
		send_str("$--");
	endtask

	task automatic test_missing_crlf();
		send_line("*1");
		send_line("$2");
		send_str("abc");
		send_line("*2");
		send_line("$1");
		send_str("a");
		send_line("");
		send_line("$1");
		send_str("b");
		send_byte(CH_CR);
		send_byte("x");
		send_line("*1");
		send_line("$0");
		send_byte(CH_LF);
	endtask

	task automatic test_arg_index_on_error();
		send_line("*3");
		send_line("$1");
		send_str("p");
		send_line("");
		send_line("$1");
		send_str("q");
		send_line("");
		send_str("#");
	endtask

	// Hold the output for a long stretch while a long request streams in
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_toggle <= ~hold_toggle;
		send_line("*3");
		for (int a = 0; a < 3; a++) begin
			send_line("$12");
			repeat (12) send_byte(BYTE_W'($urandom_range(255)));
			send_line("");
		end
		gaps_on = 1'b1;
	endtask

	// Mostly well-formed requests; the rest corrupted, cut short or noise
	task automatic test_random_stream();
		int sel;
		int pos;
		while (bytes_sent < TOTAL_BYTES) begin
			gaps_on = ($urandom_range(5) != 0);
			sel = $urandom_range(99);
			if (sel < 90)
				queue_request();
			if (sel >= 75 && sel < 90) begin
				pos = $urandom_range(stream_q.size() - 1);
				if (sel < 83) begin
					stream_q[pos] = BYTE_W'($urandom_range(255));
				end else begin
					while (stream_q.size() > pos + 1) stream_q.delete(stream_q.size() - 1);
				end
			end else if (sel >= 90) begin
				repeat ($urandom_range(4, 1)) stream_q.push_back(BYTE_W'($urandom_range(255)));
			end
			send_stream();
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bad_leading_byte();
		test_well_formed();
		test_empty_request();
		test_bad_number();
		test_overflow();
		test_length_sign();
		test_missing_crlf();
		test_arg_index_on_error();
		test_backpressure();
		test_random_stream();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
